>>> rtl/pmsm_inductance_mras_estimator_defines.svh
// Assertion macros shared by the estimator RTL.
`ifndef PMSM_INDUCTANCE_MRAS_ESTIMATOR_DEFINES_SVH
`define PMSM_INDUCTANCE_MRAS_ESTIMATOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PMSM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define PMSM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/pmie_pkg.sv
// Shared types and constants of the PMSM inductance estimator.
package pmie_pkg;

  localparam int unsigned PcW = 6;

  localparam logic        OPC_INIT  = 1'b0;
  localparam logic [30:0] EST_FLOOR = 31'd2684355;
  localparam logic [30:0] MAX31     = 31'h7FFF_FFFF;
  localparam logic signed [31:0] EST_THR = 32'sd655360;

  localparam logic [30:0] RST_R   = 31'd65536;
  localparam logic [30:0] RST_FL  = 31'd6554;
  localparam logic [30:0] RST_TO  = 31'd429497;
  localparam logic [30:0] RST_GQ  = 31'd160858112;
  localparam logic [30:0] RST_GD  = 31'd44204032;
  localparam logic [30:0] RST_ILD = 31'd268435;
  localparam logic [30:0] RST_ILQ = 31'd268435;

  typedef enum logic [2:0] {
    CFG_R   = 3'd0,
    CFG_FL  = 3'd1,
    CFG_TO  = 3'd2,
    CFG_GQ  = 3'd3,
    CFG_GD  = 3'd4,
    CFG_ILD = 3'd5,
    CFG_ILQ = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [30:0] r;
    logic [30:0] fl;
    logic [30:0] to;
    logic [30:0] gq;
    logic [30:0] gd;
    logic [30:0] ild;
    logic [30:0] ilq;
  } cfg_t;

  typedef enum logic [5:0] {
    OP_NOP, OP_END, OP_INIT_OBS,
    OP_DIV_IRLQ, OP_WB_RLQ_I, OP_DIV_IILD, OP_WB_ILD_I,
    OP_DIV_LD, OP_WB_LD, OP_DIV_LQ, OP_WB_LQ,
    OP_M_R_XD, OP_M_WE_LQ, OP_M_T1_XQ, OP_M_WE_LD, OP_M_T1_XD, OP_M_R_XQ,
    OP_M_WE_FL, OP_M_N0_TO, OP_M_N1_TO, OP_M_T1_GQ, OP_M_T1_GD, OP_M_T1_UD,
    OP_M_HI_TO, OP_M_LO_TO,
    OP_A_SETNEG16, OP_A_ADD16, OP_A_SUB16, OP_N0, OP_N1, OP_T_SH28, OP_T_SH16,
    OP_DIV_X0, OP_WB_X0, OP_DIV_X1, OP_WB_X1, OP_E_Q, OP_E_D, OP_SPLIT,
    OP_A_SET64, OP_A_ADD31, OP_WB_RLQ, OP_WB_ILD
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   load;
  } ctl_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_sts_t;

endpackage

>>> rtl/pmsm_inductance_mras_estimator.sv
// Top level of the MRAS estimator for PMSM d and q inductances.
// Each input transfer carries id, iq, ud, uq and the electrical speed (Q16.16)
// plus an opcode in tuser: init loads the current observer from the
// measurement and sets the adaptive states R/Lq and 1/Ld from the configured
// initial inductances; update takes one Euler step of the dq current model
// and one gradient step of both states. Every item yields one output
// transfer with Ld and Lq in Q3.28, each floored at 0.01 H while its state is
// below 10. Items are handled one at a time. The time an item holds the block
// is set by the bit-serial divider (four quotients for init, six for update),
// by the steps on the shared 32x32 multiplier, and by any wait for a full
// output register. Once the result enters the output register, the input is
// ready again in the next cycle.
// A finished result waits in the output register while the next item is
// already accepted.
// Configuration writes are taken at any time but must land while idle.
module pmsm_inductance_mras_estimator import pmie_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: current_d[31:0], current_q[63:32], voltage_d[95:64],
  //        voltage_q[127:96], elec_speed[159:128]
  input  logic [159:0] s_axis_tdata,
  // tuser: opcode[0]
  input  logic         s_axis_tuser,
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: ld_estimate[30:0], lq_estimate[61:31], zero[63:62]
  output logic [63:0]  m_axis_tdata,
  // configuration write channel
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [30:0]  cfg_data_i
);

  cfg_t        cfg_q, cfg_d;
  ctl_cmd_t    cmd;
  dp_sts_t     sts;
  logic        emit;
  logic        out_free;
  logic        out_valid_q, out_valid_d;
  logic [30:0] out_ld_q, out_ld_d, out_lq_q, out_lq_d;
  logic [30:0] ld_est, lq_est;

  // Register file: always ready, writes beyond the list are dropped.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_R:   cfg_d.r   = cfg_data_i;
        CFG_FL:  cfg_d.fl  = cfg_data_i;
        CFG_TO:  cfg_d.to  = cfg_data_i;
        CFG_GQ:  cfg_d.gq  = cfg_data_i;
        CFG_GD:  cfg_d.gd  = cfg_data_i;
        CFG_ILD: cfg_d.ild = cfg_data_i;
        CFG_ILQ: cfg_d.ilq = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.r   <= RST_R;
      cfg_q.fl  <= RST_FL;
      cfg_q.to  <= RST_TO;
      cfg_q.gq  <= RST_GQ;
      cfg_q.gd  <= RST_GD;
      cfg_q.ild <= RST_ILD;
      cfg_q.ilq <= RST_ILQ;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  pmie_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .opcode_i   (s_axis_tuser),
    .out_free_i (out_free),
    .emit_o     (emit),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  pmie_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_i        (cfg_q),
    .current_d_i  (s_axis_tdata[31:0]),
    .current_q_i  (s_axis_tdata[63:32]),
    .voltage_d_i  (s_axis_tdata[95:64]),
    .voltage_q_i  (s_axis_tdata[127:96]),
    .elec_speed_i (s_axis_tdata[159:128]),
    .ld_est_o     (ld_est),
    .lq_est_o     (lq_est)
  );

  // Output register: free when empty or drained in this cycle.
  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_ld_d    = out_ld_q;
    out_lq_d    = out_lq_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_ld_d    = ld_est;
      out_lq_d    = lq_est;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_ld_q <= out_ld_d;
    out_lq_q <= out_lq_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_lq_q, out_ld_q};

endmodule

>>> rtl/pmie_div.sv
// Bit-serial restoring divider, 64-bit dividend by 35-bit divisor.
module pmie_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [34:0] den_i,
  output logic [63:0] quot_o,
  output logic        done_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] quo_q, quo_d;
  logic [34:0] rem_q, rem_d;
  logic [34:0] den_q, den_d;
  logic [35:0] trial;
  logic [35:0] diff;

  assign trial = {rem_q, quo_q[63]};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '1;
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = diff[34:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = trial[34:0];
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign quot_o = quo_q;
  assign done_o = done_q;

endmodule

>>> rtl/pmie_dp.sv
// Datapath: observer and adaptive states, shared multiplier, divider.
module pmie_dp import pmie_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctl_cmd_t           cmd_i,
  output dp_sts_t            sts_o,
  input  cfg_t               cfg_i,
  input  logic signed [31:0] current_d_i,
  input  logic signed [31:0] current_q_i,
  input  logic signed [31:0] voltage_d_i,
  input  logic signed [31:0] voltage_q_i,
  input  logic signed [31:0] elec_speed_i,
  output logic [30:0]        ld_est_o,
  output logic [30:0]        lq_est_o
);

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] res;
    if (v > 64'sd2147483647) res = 32'sh7FFF_FFFF;
    else if (v < -64'sd2147483648) res = 32'sh8000_0000;
    else res = v[31:0];
    return res;
  endfunction

  // Divide by 2^k, truncating toward zero.
  function automatic logic signed [63:0] sdiv_p2(input logic signed [63:0] v,
                                                 input int unsigned k);
    logic signed [63:0] bias;
    bias = (64'sd1 <<< k) - 64'sd1;
    if (v < 0) return (v + bias) >>> k;
    return v >>> k;
  endfunction

  logic signed [31:0] id_q, iq_q, ud_q, uq_q, we_q;
  logic signed [31:0] id_d, iq_d, ud_d, uq_d, we_d;
  logic signed [31:0] xd_q, xq_q, rlq_q, ild_q;
  logic signed [31:0] xd_d, xq_d, rlq_d, ild_d;
  logic [30:0]        ld_q, lq_q, ld_d, lq_d;
  logic signed [63:0] prod_q, prod_d, acc_q, acc_d;
  logic signed [31:0] t1_q, t1_d, n0_q, n0_d, n1_q, n1_d;
  logic signed [31:0] hi_q, hi_d, lo_q, lo_d;
  logic               neg_q, neg_d;

  logic signed [31:0] ma, mb;
  logic               mul_en;
  logic               div_start;
  logic [63:0]        div_num;
  logic [34:0]        div_den;
  logic [63:0]        quot;
  logic               div_done;

  logic signed [31:0] r_s, fl_s, to_s, gq_s, gd_s, ld_s, lq_s;
  logic [30:0]        ld_cl, lq_cl, qsat;
  logic signed [63:0] prod_abs, sq, hi64;
  logic signed [31:0] sh16_v, sh28_v;

  assign r_s  = $signed({1'b0, cfg_i.r});
  assign fl_s = $signed({1'b0, cfg_i.fl});
  assign to_s = $signed({1'b0, cfg_i.to});
  assign gq_s = $signed({1'b0, cfg_i.gq});
  assign gd_s = $signed({1'b0, cfg_i.gd});
  assign ld_s = $signed({1'b0, ld_q});
  assign lq_s = $signed({1'b0, lq_q});
  assign ld_cl = (ld_q == '0) ? 31'd1 : ld_q;
  assign lq_cl = (lq_q == '0) ? 31'd1 : lq_q;
  assign qsat  = (|quot[63:31]) ? MAX31 : quot[30:0];
  assign prod_abs = prod_q[63] ? -prod_q : prod_q;
  assign sq     = neg_q ? -$signed(quot) : $signed(quot);
  assign sh16_v = sat32(sdiv_p2(prod_q, 16));
  assign sh28_v = sat32(sdiv_p2(prod_q, 28));
  assign hi64   = sdiv_p2(prod_q, 31);

  pmie_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .quot_o  (quot),
    .done_o  (div_done)
  );

  always_comb begin
    id_d = id_q; iq_d = iq_q; ud_d = ud_q; uq_d = uq_q; we_d = we_q;
    xd_d = xd_q; xq_d = xq_q; rlq_d = rlq_q; ild_d = ild_q;
    ld_d = ld_q; lq_d = lq_q;
    acc_d = acc_q; t1_d = t1_q; n0_d = n0_q; n1_d = n1_q;
    hi_d = hi_q; lo_d = lo_q; neg_d = neg_q;
    ma = '0; mb = '0; mul_en = 1'b0;
    div_start = 1'b0; div_num = '0; div_den = '0;
    if (cmd_i.load) begin
      id_d = current_d_i; iq_d = current_q_i;
      ud_d = voltage_d_i; uq_d = voltage_q_i; we_d = elec_speed_i;
    end
    case (cmd_i.op)
      OP_INIT_OBS: begin xd_d = id_q; xq_d = iq_q; end
      OP_DIV_IRLQ: begin
        div_start = 1'b1;
        div_num = {5'd0, cfg_i.r, 28'd0};
        div_den = {4'd0, cfg_i.ilq};
      end
      OP_WB_RLQ_I: rlq_d = $signed({1'b0, qsat});
      OP_DIV_IILD: begin
        div_start = 1'b1;
        div_num = 64'd1 << 44;
        div_den = {4'd0, cfg_i.ild};
      end
      OP_WB_ILD_I: ild_d = $signed({1'b0, qsat});
      OP_DIV_LD: begin
        div_start = 1'b1;
        div_num = 64'd1 << 44;
        div_den = {3'd0, ild_q};
      end
      OP_WB_LD: ld_d = (ild_q < EST_THR) ? EST_FLOOR : qsat;
      OP_DIV_LQ: begin
        div_start = 1'b1;
        div_num = {5'd0, cfg_i.r, 28'd0};
        div_den = {3'd0, rlq_q};
      end
      OP_WB_LQ: lq_d = (rlq_q < EST_THR) ? EST_FLOOR : qsat;
      OP_M_R_XD:  begin mul_en = 1'b1; ma = r_s;  mb = xd_q; end
      OP_M_WE_LQ: begin mul_en = 1'b1; ma = we_q; mb = lq_s; end
      OP_M_T1_XQ: begin mul_en = 1'b1; ma = t1_q; mb = xq_q; end
      OP_M_WE_LD: begin mul_en = 1'b1; ma = we_q; mb = ld_s; end
      OP_M_T1_XD: begin mul_en = 1'b1; ma = t1_q; mb = xd_q; end
      OP_M_R_XQ:  begin mul_en = 1'b1; ma = r_s;  mb = xq_q; end
      OP_M_WE_FL: begin mul_en = 1'b1; ma = we_q; mb = fl_s; end
      OP_M_N0_TO: begin mul_en = 1'b1; ma = n0_q; mb = to_s; end
      OP_M_N1_TO: begin mul_en = 1'b1; ma = n1_q; mb = to_s; end
      OP_M_T1_GQ: begin mul_en = 1'b1; ma = t1_q; mb = gq_s; end
      OP_M_T1_GD: begin mul_en = 1'b1; ma = t1_q; mb = gd_s; end
      OP_M_T1_UD: begin mul_en = 1'b1; ma = t1_q; mb = ud_q; end
      OP_M_HI_TO: begin mul_en = 1'b1; ma = hi_q; mb = to_s; end
      OP_M_LO_TO: begin mul_en = 1'b1; ma = lo_q; mb = to_s; end
      OP_A_SETNEG16: acc_d = -64'(sh16_v);
      OP_A_ADD16:    acc_d = acc_q + 64'(sh16_v);
      OP_A_SUB16:    acc_d = acc_q - 64'(sh16_v);
      OP_N0:         n0_d = sat32(acc_q + 64'(ud_q));
      OP_N1:         n1_d = sat32(acc_q + 64'(uq_q));
      OP_T_SH28:     t1_d = sh28_v;
      OP_T_SH16:     t1_d = sh16_v;
      OP_DIV_X0: begin
        div_start = 1'b1;
        div_num = prod_abs;
        div_den = {1'b0, ld_cl, 3'b000};
        neg_d = prod_q[63];
      end
      OP_WB_X0: xd_d = sat32(64'(xd_q) + sq);
      OP_DIV_X1: begin
        div_start = 1'b1;
        div_num = prod_abs;
        div_den = {1'b0, lq_cl, 3'b000};
        neg_d = prod_q[63];
      end
      OP_WB_X1: xq_d = sat32(64'(xq_q) + sq);
      OP_E_Q:   t1_d = sat32(64'(iq_q) - 64'(xq_q));
      OP_E_D:   t1_d = sat32(64'(id_q) - 64'(xd_q));
      OP_SPLIT: begin
        hi_d = hi64[31:0];
        lo_d = 32'(prod_q - (hi64 <<< 31));
      end
      OP_A_SET64: acc_d = prod_q;
      OP_A_ADD31: acc_d = acc_q + hi64;
      OP_WB_RLQ:  rlq_d = sat32(64'(rlq_q) + sdiv_p2(acc_q, 16));
      OP_WB_ILD:  ild_d = sat32(64'(ild_q) + sdiv_p2(acc_q, 16));
      default: ;
    endcase
  end

  assign prod_d = mul_en ? (64'(ma) * 64'(mb)) : prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xd_q  <= '0;
      xq_q  <= '0;
      rlq_q <= '0;
      ild_q <= '0;
    end else begin
      xd_q  <= xd_d;
      xq_q  <= xq_d;
      rlq_q <= rlq_d;
      ild_q <= ild_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d; iq_q <= iq_d; ud_q <= ud_d; uq_q <= uq_d; we_q <= we_d;
    ld_q <= ld_d; lq_q <= lq_d;
    prod_q <= prod_d; acc_q <= acc_d;
    t1_q <= t1_d; n0_q <= n0_d; n1_q <= n1_d;
    hi_q <= hi_d; lo_q <= lo_d; neg_q <= neg_d;
  end

  assign sts_o.div_done = div_done;
  assign ld_est_o = ld_q;
  assign lq_est_o = lq_q;

endmodule

>>> rtl/pmie_ctrl.sv
// Controller: microprogram sequencer that drives the datapath.
`include "pmsm_inductance_mras_estimator_defines.svh"
module pmie_ctrl import pmie_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     opcode_i,
  input  logic     out_free_i,
  output logic     emit_o,
  output ctl_cmd_t cmd_o,
  input  dp_sts_t  sts_i
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_WAIT = 3'b100
  } state_e;

  function automatic dp_op_e prog_op(input logic opc, input logic [PcW-1:0] pc);
    dp_op_e op;
    op = OP_END;
    if (opc == OPC_INIT) begin
      case (pc)
        6'd0: op = OP_INIT_OBS;
        6'd1: op = OP_DIV_IRLQ;
        6'd2: op = OP_WB_RLQ_I;
        6'd3: op = OP_DIV_IILD;
        6'd4: op = OP_WB_ILD_I;
        6'd5: op = OP_DIV_LD;
        6'd6: op = OP_WB_LD;
        6'd7: op = OP_DIV_LQ;
        6'd8: op = OP_WB_LQ;
        default: op = OP_END;
      endcase
    end else begin
      case (pc)
        6'd0:  op = OP_DIV_LD;
        6'd1:  op = OP_WB_LD;
        6'd2:  op = OP_DIV_LQ;
        6'd3:  op = OP_WB_LQ;
        6'd4:  op = OP_M_R_XD;
        6'd5:  op = OP_A_SETNEG16;
        6'd6:  op = OP_M_WE_LQ;
        6'd7:  op = OP_T_SH28;
        6'd8:  op = OP_M_T1_XQ;
        6'd9:  op = OP_A_ADD16;
        6'd10: op = OP_N0;
        6'd11: op = OP_M_WE_LD;
        6'd12: op = OP_T_SH28;
        6'd13: op = OP_M_T1_XD;
        6'd14: op = OP_A_SETNEG16;
        6'd15: op = OP_M_R_XQ;
        6'd16: op = OP_A_SUB16;
        6'd17: op = OP_M_WE_FL;
        6'd18: op = OP_A_SUB16;
        6'd19: op = OP_N1;
        6'd20: op = OP_M_N0_TO;
        6'd21: op = OP_DIV_X0;
        6'd22: op = OP_WB_X0;
        6'd23: op = OP_M_N1_TO;
        6'd24: op = OP_DIV_X1;
        6'd25: op = OP_WB_X1;
        6'd26: op = OP_E_Q;
        6'd27: op = OP_M_T1_XQ;
        6'd28: op = OP_T_SH16;
        6'd29: op = OP_M_T1_GQ;
        6'd30: op = OP_SPLIT;
        6'd31: op = OP_M_HI_TO;
        6'd32: op = OP_A_SET64;
        6'd33: op = OP_M_LO_TO;
        6'd34: op = OP_A_ADD31;
        6'd35: op = OP_WB_RLQ;
        6'd36: op = OP_E_D;
        6'd37: op = OP_M_T1_UD;
        6'd38: op = OP_T_SH16;
        6'd39: op = OP_M_T1_GD;
        6'd40: op = OP_SPLIT;
        6'd41: op = OP_M_HI_TO;
        6'd42: op = OP_A_SET64;
        6'd43: op = OP_M_LO_TO;
        6'd44: op = OP_A_ADD31;
        6'd45: op = OP_WB_ILD;
        6'd46: op = OP_DIV_LD;
        6'd47: op = OP_WB_LD;
        6'd48: op = OP_DIV_LQ;
        6'd49: op = OP_WB_LQ;
        default: op = OP_END;
      endcase
    end
    return op;
  endfunction

  function automatic logic op_is_div(input dp_op_e op);
    return op == OP_DIV_IRLQ || op == OP_DIV_IILD || op == OP_DIV_LD ||
           op == OP_DIV_LQ || op == OP_DIV_X0 || op == OP_DIV_X1;
  endfunction

  state_e         state_q, state_d;
  logic [PcW-1:0] pc_q, pc_d;
  logic           opc_q, opc_d;
  dp_op_e         cur_op;

  assign cur_op = prog_op(opc_q, pc_q);

  always_comb begin
    state_d    = state_q;
    pc_d       = pc_q;
    opc_d      = opc_q;
    in_ready_o = 1'b0;
    emit_o     = 1'b0;
    cmd_o.op   = OP_NOP;
    cmd_o.load = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          opc_d      = opcode_i;
          pc_d       = '0;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.op = cur_op;
        if (cur_op == OP_END) begin
          // hold until the output register can take the result
          if (out_free_i) begin
            emit_o  = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          pc_d = pc_q + 1'b1;
          if (op_is_div(cur_op)) state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        if (sts_i.div_done) state_d = S_EXEC;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q    <= '0;
      opc_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      opc_q   <= opc_d;
    end
  end

  `PMSM_ASSERT(a_done_in_wait, clk_i, rst_ni, sts_i.div_done |-> state_q == S_WAIT, "divider finished outside wait")
  `PMSM_ASSERT(a_emit_free, clk_i, rst_ni, emit_o |-> out_free_i, "result emitted over a pending one")
  `PMSM_ASSERT_NEXT(a_accept_start, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == S_EXEC && pc_q == '0, "accepted item did not start program")

endmodule
